@@ rtl/ptbl_pkg.sv @@
package ptbl_pkg;

  // Bucket array and field widths
  localparam int NUM_CODES    = 256;
  localparam int IDX_W        = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
  localparam int CODE_W       = 8;
  localparam int STATUS_W     = 16;
  localparam int TIME_W       = 48;
  localparam int TOK_W        = 16;
  localparam int RATE_W       = 10;
  localparam int BURST_W      = 7;
  localparam int ELAP_LO_W    = 16;
  localparam int PROD_W       = ELAP_LO_W + RATE_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int CAP_W        = BURST_W + RATE_W;

  // Configuration port
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_W        = RATE_W;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST = 1'd1;

  // Constants
  localparam logic [TOK_W-1:0]   EVENT_COST   = 16'd1000;
  localparam logic [BURST_W-1:0] BURST_MAX    = 7'd64;
  localparam logic [TOK_W-1:0]   TOKENS_RESET = 16'd64000;
  localparam logic [RATE_W-1:0]  RATE_RESET   = 10'd10;
  localparam logic [BURST_W-1:0] BURST_RESET  = 7'd10;

  // Refill result handed from the arithmetic pipe to the write-back stage
  typedef struct packed {
    logic              sat;
    logic [PROD_W-1:0] prod;
    logic [TOK_W-1:0]  tokens;
  } refill_t;

  // Reduce a status code to a bucket index (code mod NUM_CODES) by restoring
  // subtraction, one shifted multiple of the bucket count per step.
  function automatic logic [IDX_W-1:0] code_to_idx(input logic [CODE_W-1:0] code);
    logic [CODE_W+8:0] rem;
    logic [CODE_W+8:0] step;
    rem = (CODE_W+9)'(code);
    for (int k = CODE_W - 1; k >= 0; k--) begin
      step = (CODE_W+9)'(NUM_CODES) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/ptbl_refill.sv @@
module ptbl_refill (
  input  logic                         clk,
  input  logic                         ld_a,
  input  logic                         ld_b,
  input  logic [ptbl_pkg::TIME_W-1:0]  stored_time,
  input  logic [ptbl_pkg::TOK_W-1:0]   stored_tokens,
  input  logic [ptbl_pkg::TIME_W-1:0]  now_ms,
  input  logic [ptbl_pkg::RATE_W-1:0]  rate,
  output ptbl_pkg::refill_t            refill
);
  import ptbl_pkg::*;

  logic [TIME_W-1:0]    elapsed;
  logic [ELAP_LO_W-1:0] elap_lo_r;
  logic                 elap_big_r;
  logic [TOK_W-1:0]     tok_a_r;
  refill_t              refill_r;

  // Elapsed time; a step backwards counts as nothing elapsed
  assign elapsed = (now_ms > stored_time) ? (now_ms - stored_time) : '0;

  // Stage A: hold low elapsed bits and flag a span too long to refill exactly
  always_ff @(posedge clk) begin
    if (ld_a) begin
      elap_lo_r  <= elapsed[ELAP_LO_W-1:0];
      elap_big_r <= |elapsed[TIME_W-1:ELAP_LO_W];
      tok_a_r    <= stored_tokens;
    end
  end

  // Stage B: multiply by the rate; a long span with nonzero rate always fills the bucket
  always_ff @(posedge clk) begin
    if (ld_b) begin
      refill_r.sat    <= elap_big_r && (rate != '0);
      refill_r.prod   <= PROD_W'(elap_lo_r) * PROD_W'(rate);
      refill_r.tokens <= tok_a_r;
    end
  end

  assign refill = refill_r;

endmodule

@@ rtl/per_code_token_bucket_limiter_unit.sv @@
// Per-status-code token bucket limiter.
// A request is taken at a clock edge with start high and busy low; it carries
// the raw completion status word and a millisecond timestamp. Status bits 8:1
// pick one of NUM_CODES buckets held in an on-chip memory together with the
// time each bucket was last touched.
// Each request gives one result: out_valid is high for exactly one cycle with
// out_allow_event, out_status_code and out_tokens_left. The receiver cannot
// stall, so the result is gone after that cycle.
// out_valid rises once the request has passed the bucket memory read-modify-write:
// read, elapsed time, multiply by the rate, then cap, debit and write back,
// with busy held over the sequence, so a new request is not taken until the
// last one has been written back.
// Reset sets rate 10 and burst 10 and marks every bucket untouched in a
// per-entry valid vector; an untouched bucket reads as full with time zero,
// so no clearing pass is needed and a request can be taken right after reset.
// The cfg port writes rate (index 0) or burst (index 1); the user is to write it only
// while no request is in flight, as the block itself does not enforce this.
module per_code_token_bucket_limiter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [ptbl_pkg::STATUS_W-1:0]   in_status_word,
  input  logic [ptbl_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  output logic                            out_allow_event,
  output logic [ptbl_pkg::CODE_W-1:0]     out_status_code,
  output logic [ptbl_pkg::TOK_W-1:0]      out_tokens_left,
  input  logic                            cfg_we,
  input  logic [ptbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptbl_pkg::CFG_W-1:0]      cfg_wdata
);
  import ptbl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_MUL   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [RATE_W-1:0]    rate_r;
  logic [BURST_W-1:0]   burst_r;

  logic                 accept;
  logic [CODE_W-1:0]    in_code;
  logic [IDX_W-1:0]     in_idx;

  logic [CODE_W-1:0]    code_r;
  logic [IDX_W-1:0]     idx_r;
  logic [TIME_W-1:0]    now_r;

  logic [TIME_W+TOK_W-1:0] mem [NUM_CODES];
  logic [TIME_W+TOK_W-1:0] rd_data_r;
  logic [NUM_CODES-1:0]    vld_r;
  logic                    rd_vld_r;

  logic [TIME_W-1:0]    stored_time;
  logic [TOK_W-1:0]     stored_tokens;
  refill_t              refill;

  logic [BURST_W-1:0]   burst_eff;
  logic [CAP_W-1:0]     cap;
  logic [SUM_W-1:0]     sum;
  logic [TOK_W-1:0]     capped;
  logic                 allow;
  logic [TOK_W-1:0]     new_tokens;

  logic                 out_valid_r;
  logic                 out_allow_r;
  logic [CODE_W-1:0]    out_code_r;
  logic [TOK_W-1:0]     out_tokens_r;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign in_code = in_status_word[CODE_W:1];
  assign in_idx  = code_to_idx(in_code);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RESET;
      burst_r <= BURST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE:  rate_r  <= cfg_wdata[RATE_W-1:0];
        REG_BURST: burst_r <= cfg_wdata[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence one request through read, elapsed, multiply and write-back
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_code;
      idx_r  <= in_idx;
      now_r  <= in_now_ms;
    end
  end

  // Bucket memory: read on accept, write back at the end of the request
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[in_idx];
    end
    if (state_r == S_WRITE) begin
      mem[idx_r] <= {now_r, new_tokens};
    end
  end

  // Track which buckets have been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_r <= vld_r[in_idx];
      end
      if (state_r == S_WRITE) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // An untouched bucket reads as full with time zero
  assign stored_time   = rd_vld_r ? rd_data_r[TIME_W+TOK_W-1:TOK_W] : '0;
  assign stored_tokens = rd_vld_r ? rd_data_r[TOK_W-1:0] : TOKENS_RESET;

  ptbl_refill u_refill (
    .clk           (clk),
    .ld_a          (state_r == S_READ),
    .ld_b          (state_r == S_MUL),
    .stored_time   (stored_time),
    .stored_tokens (stored_tokens),
    .now_ms        (now_r),
    .rate          (rate_r),
    .refill        (refill)
  );

  // Cap the refilled allowance and debit one event if there is room
  assign burst_eff  = (burst_r > BURST_MAX) ? BURST_MAX : burst_r;
  assign cap        = CAP_W'(burst_eff) * CAP_W'(EVENT_COST);
  assign sum        = SUM_W'(refill.tokens) + SUM_W'(refill.prod);
  assign capped     = (refill.sat || (sum > SUM_W'(cap))) ? cap[TOK_W-1:0]
                                                          : sum[TOK_W-1:0];
  assign allow      = (capped >= EVENT_COST);
  assign new_tokens = allow ? (capped - EVENT_COST) : capped;

  // Drive the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      out_allow_r  <= allow;
      out_code_r   <= code_r;
      out_tokens_r <= new_tokens;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_allow_event = out_allow_r;
  assign out_status_code = out_code_r;
  assign out_tokens_left = out_tokens_r;

endmodule
